>>> sv/crz_pkg.sv
// ----------------------------------------------------------------------------
// crz_pkg
// Widths, constants and shared types of the circle rasterizer.
// ----------------------------------------------------------------------------
package crz_pkg;

   localparam int COORD_BITS  = 12;
   localparam int STEP_BITS   = 11;
   localparam int DEC_BITS    = 16;
   localparam int RADIUS_BITS = 10;
   localparam int COLOR_BITS  = 8;
   localparam int CLIP_BITS   = 11;
   localparam int PIXEL_BITS  = 13;
   localparam int OFS_BITS    = STEP_BITS + 1;
   localparam int SUM_BITS    = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 1;
   localparam int WRITES      = 8;
   localparam int WRITE_BITS  = $clog2(WRITES);

   localparam logic [CLIP_BITS-1:0] CLIP_RESET = CLIP_BITS'(800);

   localparam logic [DEC_BITS-1:0] DEC_INIT   = DEC_BITS'(3);
   localparam logic [DEC_BITS-1:0] DEC_INC_UP = DEC_BITS'(10);
   localparam logic [DEC_BITS-1:0] DEC_INC_FL = DEC_BITS'(6);

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } opcode_type;

   // one group of eight symmetric writes
   typedef struct packed {
      logic                         blank;
      logic                         done;
      logic signed [OFS_BITS-1:0]   ofs_x;
      logic signed [OFS_BITS-1:0]   ofs_y;
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic [COLOR_BITS-1:0]        color;
   } group_type;

endpackage

>>> sv/crz_req_if.sv
// ----------------------------------------------------------------------------
// crz_req_if
// Request channel: start or step words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crz_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic signed [crz_pkg::COORD_BITS-1:0] center_x;
   logic signed [crz_pkg::COORD_BITS-1:0] center_y;
   logic [crz_pkg::RADIUS_BITS-1:0]       radius;
   logic [crz_pkg::COLOR_BITS-1:0]        color;

   modport source (
      output valid, opcode, center_x, center_y, radius, color,
      input  ready
   );
   modport sink (
      input  valid, opcode, center_x, center_y, radius, color,
      output ready
   );
endinterface

>>> sv/crz_rsp_if.sv
// ----------------------------------------------------------------------------
// crz_rsp_if
// Response channel: one pixel write per word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crz_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [crz_pkg::PIXEL_BITS-1:0] pixel_x;
   logic signed [crz_pkg::PIXEL_BITS-1:0] pixel_y;
   logic [crz_pkg::COLOR_BITS-1:0]        color_out;
   logic                                  inside_res;
   logic                                  last;
   logic                                  done_res;

   modport source (
      output valid, pixel_x, pixel_y, color_out, inside_res, last, done_res,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, color_out, inside_res, last, done_res,
      output ready
   );
endinterface

>>> sv/crz_emitter.sv
// ----------------------------------------------------------------------------
// crz_emitter
// Holds one group and sends its eight symmetric writes, one per cycle
// while rsp_ch does not stall, through a registered output stage with clipping.
// ----------------------------------------------------------------------------
module crz_emitter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               group_load,
   input  crz_pkg::group_type                 group_data,
   output logic                               group_free,
   input  logic [crz_pkg::CLIP_BITS-1:0]      clip_limit,
   crz_rsp_if.source                          rsp_ch
);

   crz_pkg::group_type                      group_ff;
   logic                                    group_valid_ff, group_valid_in;
   logic [crz_pkg::WRITE_BITS-1:0]          cnt_ff, cnt_in;

   logic                                    out_valid_ff, out_valid_in;
   logic signed [crz_pkg::PIXEL_BITS-1:0]   out_x_ff, out_x_in;
   logic signed [crz_pkg::PIXEL_BITS-1:0]   out_y_ff, out_y_in;
   logic [crz_pkg::COLOR_BITS-1:0]          out_color_ff, out_color_in;
   logic                                    out_inside_ff, out_inside_in;
   logic                                    out_last_ff, out_last_in;
   logic                                    out_done_ff, out_done_in;

   logic                                    emit;
   logic                                    emit_last;
   logic signed [crz_pkg::OFS_BITS-1:0]     ofs_a, ofs_b;
   logic signed [crz_pkg::SUM_BITS-1:0]     ext_a, ext_b;
   logic signed [crz_pkg::SUM_BITS-1:0]     px, py;
   logic [crz_pkg::SUM_BITS-1:0]            clip_ext;
   logic                                    in_square;

   assign emit       = group_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign emit_last  = emit && (cnt_ff == crz_pkg::WRITE_BITS'(crz_pkg::WRITES - 1));
   assign group_free = !group_valid_ff || emit_last;

   // write order: bit 2 swaps the axes, bit 0 negates x, bit 1 negates y
   always_comb begin
      ofs_a     = cnt_ff[2] ? group_ff.ofs_y : group_ff.ofs_x;
      ofs_b     = cnt_ff[2] ? group_ff.ofs_x : group_ff.ofs_y;
      ext_a     = crz_pkg::SUM_BITS'(ofs_a);
      ext_b     = crz_pkg::SUM_BITS'(ofs_b);
      px        = crz_pkg::SUM_BITS'(group_ff.center_x) + (cnt_ff[0] ? -ext_a : ext_a);
      py        = crz_pkg::SUM_BITS'(group_ff.center_y) + (cnt_ff[1] ? -ext_b : ext_b);
      clip_ext  = crz_pkg::SUM_BITS'(clip_limit);
      in_square = !px[crz_pkg::SUM_BITS-1] && !py[crz_pkg::SUM_BITS-1] &&
                  (px < clip_ext) && (py < clip_ext);
   end

   always_comb begin
      group_valid_in = group_valid_ff;
      cnt_in         = cnt_ff;
      if (emit) begin
         cnt_in = cnt_ff + crz_pkg::WRITE_BITS'(1);
      end
      if (emit_last) begin
         group_valid_in = 1'b0;
      end
      if (group_load) begin
         group_valid_in = 1'b1;
         cnt_in         = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_color_in  = out_color_ff;
      out_inside_in = out_inside_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = emit_last;
         out_done_in  = group_ff.done;
         if (group_ff.blank) begin
            out_x_in      = '0;
            out_y_in      = '0;
            out_color_in  = '0;
            out_inside_in = 1'b0;
         end else begin
            out_x_in      = px[crz_pkg::PIXEL_BITS-1:0];
            out_y_in      = py[crz_pkg::PIXEL_BITS-1:0];
            out_color_in  = group_ff.color;
            out_inside_in = in_square;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_valid_ff <= 1'b0;
         cnt_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         group_valid_ff <= group_valid_in;
         cnt_ff         <= cnt_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (group_load) begin
         group_ff <= group_data;
      end
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_color_ff  <= out_color_in;
      out_inside_ff <= out_inside_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pixel_x    = out_x_ff;
   assign rsp_ch.pixel_y    = out_y_ff;
   assign rsp_ch.color_out  = out_color_ff;
   assign rsp_ch.inside_res = out_inside_ff;
   assign rsp_ch.last       = out_last_ff;
   assign rsp_ch.done_res   = out_done_ff;

endmodule

>>> sv/circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_unit
// Midpoint circle rasterizer with eight-way symmetry and square clipping.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one word per command. A start word (opcode 0) loads the
//   center, radius and color and produces the first group; a step word
//   (opcode 1) advances the midpoint walk by one step and produces the group
//   for the new point. A step with no circle in progress gives eight blank
//   writes with done_res set.
//   rsp_ch carries eight pixel writes per request word, in fixed symmetric
//   order; last marks the eighth, done_res marks groups after which no step
//   is left. inside_res says whether both coordinates lie in [0, clip_limit).
//   csr_we / csr_wdata write clip_limit (reset 800); write only when idle.
// Timing:
//   the walk update is done in the accept cycle; the group register then
//   drives the output register one write per cycle; the first write is
//   valid once it is in the output register. The single response port
//   takes the eight writes of each request; the next request is taken in
//   the cycle the eighth write of the current group leaves the group
//   register. A stalled rsp_ch holds the output word and stops the drain.
// Reset: synchronous; clears the walk state and pending writes, sets
//   clip_limit back to 800; req_ch is not ready while reset is high.
// ----------------------------------------------------------------------------
module circle_rasterizer_unit (
   input  logic                          clock,
   input  logic                          reset,
   crz_req_if.sink                       req_ch,
   crz_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [crz_pkg::CLIP_BITS-1:0] csr_wdata
);

   logic [crz_pkg::CLIP_BITS-1:0]           clip_ff, clip_in;
   logic [crz_pkg::STEP_BITS-1:0]           step_x_ff, step_x_in;
   logic signed [crz_pkg::STEP_BITS-1:0]    step_y_ff, step_y_in;
   logic signed [crz_pkg::DEC_BITS-1:0]     decision_ff, decision_in;
   logic signed [crz_pkg::COORD_BITS-1:0]   center_x_ff, center_x_in;
   logic signed [crz_pkg::COORD_BITS-1:0]   center_y_ff, center_y_in;
   logic [crz_pkg::COLOR_BITS-1:0]          color_ff, color_in;
   logic                                    active_ff, active_in;

   logic                                    accept;
   logic                                    group_free;
   crz_pkg::group_type                      group_data;

   logic [crz_pkg::STEP_BITS-1:0]           x_next;
   logic signed [crz_pkg::STEP_BITS-1:0]    y_next;
   logic [crz_pkg::DEC_BITS-1:0]            x_wide, y_wide, dec_up, dec_flat;
   logic                                    dec_pos;
   logic                                    step_done;

   assign req_ch.ready = group_free && !reset;
   assign accept       = req_ch.valid && group_free && !reset;

   // one midpoint step from the held point
   always_comb begin
      x_next   = step_x_ff + crz_pkg::STEP_BITS'(1);
      dec_pos  = !decision_ff[crz_pkg::DEC_BITS-1] && (decision_ff != '0);
      y_next   = dec_pos ? (step_y_ff - crz_pkg::STEP_BITS'(1)) : step_y_ff;
      x_wide   = crz_pkg::DEC_BITS'(x_next);
      y_wide   = crz_pkg::DEC_BITS'(y_next);
      dec_up   = decision_ff + ((x_wide - y_wide) << 2) + crz_pkg::DEC_INC_UP;
      dec_flat = decision_ff + (x_wide << 2) + crz_pkg::DEC_INC_FL;
      step_done = y_next < $signed({1'b0, x_next});
   end

   always_comb begin
      clip_in     = csr_we ? csr_wdata : clip_ff;
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      decision_in = decision_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      color_in    = color_ff;
      active_in   = active_ff;

      group_data.blank    = 1'b0;
      group_data.done     = 1'b0;
      group_data.ofs_x    = crz_pkg::OFS_BITS'(x_next);
      group_data.ofs_y    = crz_pkg::OFS_BITS'(y_next);
      group_data.center_x = center_x_ff;
      group_data.center_y = center_y_ff;
      group_data.color    = color_ff;

      if (accept) begin
         if (req_ch.opcode == crz_pkg::OP_START) begin
            step_x_in   = '0;
            step_y_in   = crz_pkg::STEP_BITS'(req_ch.radius);
            decision_in = crz_pkg::DEC_INIT -
                          (crz_pkg::DEC_BITS'(req_ch.radius) << 1);
            center_x_in = req_ch.center_x;
            center_y_in = req_ch.center_y;
            color_in    = req_ch.color;
            active_in   = 1'b1;
            group_data.ofs_x    = '0;
            group_data.ofs_y    = crz_pkg::OFS_BITS'(req_ch.radius);
            group_data.center_x = req_ch.center_x;
            group_data.center_y = req_ch.center_y;
            group_data.color    = req_ch.color;
         end else if (active_ff) begin
            step_x_in   = x_next;
            step_y_in   = y_next;
            decision_in = dec_pos ? dec_up : dec_flat;
            active_in   = !step_done;
            group_data.done = step_done;
         end else begin
            // no circle in progress
            group_data.blank = 1'b1;
            group_data.done  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff     <= crz_pkg::CLIP_RESET;
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         decision_ff <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         color_ff    <= '0;
         active_ff   <= 1'b0;
      end else begin
         clip_ff     <= clip_in;
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         decision_ff <= decision_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         color_ff    <= color_in;
         active_ff   <= active_in;
      end
   end

   crz_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .group_load (accept),
      .group_data (group_data),
      .group_free (group_free),
      .clip_limit (clip_ff),
      .rsp_ch     (rsp_ch)
   );

endmodule

>>> sv/crz_checker.sv
// ----------------------------------------------------------------------------
// crz_checker
// Port-level checks of the circle rasterizer response channel.
// ----------------------------------------------------------------------------
module crz_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [crz_pkg::PIXEL_BITS-1:0] rsp_pixel_x,
   input logic signed [crz_pkg::PIXEL_BITS-1:0] rsp_pixel_y,
   input logic                                  rsp_inside,
   input logic                                  rsp_last
);

   // nothing pending right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // stalled word holds
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_last))
      else $error("stalled response word changed");

   // the eight writes of a group leave without gaps
   a_group_gapless : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a write group");

   // clipped-in writes never have negative coordinates
   a_inside_nonneg : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside |->
         !rsp_pixel_x[crz_pkg::PIXEL_BITS-1] && !rsp_pixel_y[crz_pkg::PIXEL_BITS-1])
      else $error("inside write with negative coordinate");

endmodule

bind circle_rasterizer_unit crz_checker u_crz_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_pixel_x (rsp_ch.pixel_x),
   .rsp_pixel_y (rsp_ch.pixel_y),
   .rsp_inside  (rsp_ch.inside_res),
   .rsp_last    (rsp_ch.last)
);

>>> sim/circle_rasterizer_unit_tb.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_unit_tb
// Drives start and step words into the circle rasterizer under random
// backpressure and checks every pixel write against a midpoint-walk tracker
// that follows the same eight-way symmetric order and square clipping.
// ----------------------------------------------------------------------------
module circle_rasterizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      logic signed [crz_pkg::PIXEL_BITS-1:0] pixel_x;
      logic signed [crz_pkg::PIXEL_BITS-1:0] pixel_y;
      logic [crz_pkg::COLOR_BITS-1:0]        color;
      logic                                  in_clip;
      logic                                  last;
      logic                                  done;
   } pixel_write_type;

   // tracks the midpoint walk and the pixel writes still owed by the block
   class circle_walk_model;
      int unsigned                           clip;
      logic signed [crz_pkg::COORD_BITS-1:0] ctr_x;
      logic signed [crz_pkg::COORD_BITS-1:0] ctr_y;
      logic [crz_pkg::COLOR_BITS-1:0]        shade;
      logic signed [crz_pkg::STEP_BITS-1:0]  walk_x;
      logic signed [crz_pkg::STEP_BITS-1:0]  walk_y;
      logic signed [crz_pkg::DEC_BITS-1:0]   decision;
      bit                                    running;
      pixel_write_type                       pending_writes[$];
      int                                    failures;

      function new();
         clip     = 800;
         ctr_x    = '0;
         ctr_y    = '0;
         shade    = '0;
         walk_x   = '0;
         walk_y   = '0;
         decision = '0;
         running  = 1'b0;
         failures = 0;
      endfunction

      function void queue_write(pixel_write_type w);
         pending_writes.insert(pending_writes.size(), w);
      endfunction

      function void push_group(bit done);
         int x;
         int y;
         int px;
         int py;
         int ox[8];
         int oy[8];
         pixel_write_type w;
         x = walk_x;
         y = walk_y;
         ox = '{x, -x, x, -x, y, -y, y, -y};
         oy = '{y, y, -y, -y, x, x, -x, -x};
         for (int k = 0; k < crz_pkg::WRITES; k++) begin
            px = int'(ctr_x) + ox[k];
            py = int'(ctr_y) + oy[k];
            w.pixel_x = crz_pkg::PIXEL_BITS'(px);
            w.pixel_y = crz_pkg::PIXEL_BITS'(py);
            w.color   = shade;
            w.in_clip = (px >= 0) && (py >= 0) && (px < int'(clip)) && (py < int'(clip));
            w.last    = (k == crz_pkg::WRITES - 1);
            w.done    = done;
            queue_write(w);
         end
      endfunction

      function void take_command(crz_pkg::opcode_type op,
                                 logic signed [crz_pkg::COORD_BITS-1:0] cx,
                                 logic signed [crz_pkg::COORD_BITS-1:0] cy,
                                 logic [crz_pkg::RADIUS_BITS-1:0] r,
                                 logic [crz_pkg::COLOR_BITS-1:0] col);
         int x;
         int y;
         int d;
         bit done;
         pixel_write_type w;
         if (op == crz_pkg::OP_START) begin
            ctr_x    = cx;
            ctr_y    = cy;
            shade    = col;
            walk_x   = '0;
            walk_y   = crz_pkg::STEP_BITS'(int'(r));
            decision = crz_pkg::DEC_BITS'(3 - 2 * int'(r));
            running  = 1'b1;
            push_group(1'b0);
         end else if (!running) begin
            // step with nothing in progress: blank writes, done set
            w = '0;
            w.done = 1'b1;
            for (int k = 0; k < crz_pkg::WRITES; k++) begin
               w.last = (k == crz_pkg::WRITES - 1);
               queue_write(w);
            end
         end else begin
            x = int'(walk_x) + 1;
            y = walk_y;
            d = decision;
            if (d > 0) begin
               y = y - 1;
               d = d + 4 * (x - y) + 10;
            end else begin
               d = d + 4 * x + 6;
            end
            walk_x   = crz_pkg::STEP_BITS'(x);
            walk_y   = crz_pkg::STEP_BITS'(y);
            decision = crz_pkg::DEC_BITS'(d);
            done = (y < x);
            push_group(done);
            if (done) running = 1'b0;
         end
      endfunction

      function void field_ok(string name, logic signed [15:0] want, logic signed [15:0] got);
         if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_write(pixel_write_type got);
         pixel_write_type want;
         if (pending_writes.size() == 0) begin
            $error("pixel write (%0d,%0d) with no word outstanding", got.pixel_x, got.pixel_y);
            failures++;
            return;
         end
         want = pending_writes.pop_front();
         field_ok("pixel_x", want.pixel_x, got.pixel_x);
         field_ok("pixel_y", want.pixel_y, got.pixel_y);
         field_ok("color_out", {8'b0, want.color}, {8'b0, got.color});
         field_ok("inside_res", {15'b0, want.in_clip}, {15'b0, got.in_clip});
         field_ok("last", {15'b0, want.last}, {15'b0, got.last});
         field_ok("done_res", {15'b0, want.done}, {15'b0, got.done});
      endfunction

      function void check_drained();
         if (pending_writes.size() != 0) begin
            $error("%0d pixel writes never arrived", pending_writes.size());
            failures++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [crz_pkg::CLIP_BITS-1:0]   csr_wdata;

   crz_req_if req_ch();
   crz_rsp_if rsp_ch();

   circle_rasterizer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   circle_walk_model walk;
   int               words_sent;
   int               writes_seen = 0;
   bit               hold_writes;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("circle_rasterizer_unit_tb NOT OK");
      $finish;
   end

   function automatic int sender_gap();
      return ((words_sent / 16) % 3 == 2) ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic int sink_gap();
      return ((writes_seen / 48) % 3 == 1) ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic signed [crz_pkg::COORD_BITS-1:0] pick_center();
      case ($urandom_range(0, 2))
         0: return crz_pkg::COORD_BITS'($urandom);
         1: return crz_pkg::COORD_BITS'($urandom_range(0, walk.clip));
         default: return crz_pkg::COORD_BITS'(int'($urandom_range(0, 16)) - 8);
      endcase
   endfunction

   task automatic send_word(crz_pkg::opcode_type op,
                            logic signed [crz_pkg::COORD_BITS-1:0] cx,
                            logic signed [crz_pkg::COORD_BITS-1:0] cy,
                            logic [crz_pkg::RADIUS_BITS-1:0] r,
                            logic [crz_pkg::COLOR_BITS-1:0] col);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.opcode   <= op;
      req_ch.center_x <= cx;
      req_ch.center_y <= cy;
      req_ch.radius   <= r;
      req_ch.color    <= col;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      walk.take_command(op, cx, cy, r, col);
      words_sent++;
   endtask

   // step words carry junk in the start-only fields
   task automatic send_step();
      send_word(crz_pkg::OP_STEP, crz_pkg::COORD_BITS'($urandom),
                crz_pkg::COORD_BITS'($urandom), crz_pkg::RADIUS_BITS'($urandom),
                crz_pkg::COLOR_BITS'($urandom));
   endtask

   task automatic send_start(logic [crz_pkg::RADIUS_BITS-1:0] r);
      send_word(crz_pkg::OP_START, pick_center(), pick_center(), r,
                crz_pkg::COLOR_BITS'($urandom));
   endtask

   task automatic wait_all_written();
      while (walk.pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic set_clip_limit(int unsigned value);
      req_ch.valid <= 1'b0;
      wait_all_written();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= crz_pkg::CLIP_BITS'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      walk.clip = value;
   endtask

   // mostly complete circles, some abandoned big ones and stray steps
   task automatic random_phase(int budget);
      int used;
      int steps;
      int kind;
      used = 0;
      while (used < budget) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_step();
            used++;
         end else if (kind == 1) begin
            send_start(crz_pkg::RADIUS_BITS'($urandom_range(0, 1023)));
            used++;
            steps = $urandom_range(0, 3);
            repeat (steps) send_step();
            used += steps;
         end else begin
            send_start(crz_pkg::RADIUS_BITS'($urandom_range(0, 24)));
            used++;
            while (walk.running && used < budget + 12) begin
               send_step();
               used++;
            end
         end
      end
   endtask

   initial begin : write_sink
      int gap;
      bit held;
      pixel_write_type got;
      gap = 0;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.pixel_x = rsp_ch.pixel_x;
            got.pixel_y = rsp_ch.pixel_y;
            got.color   = rsp_ch.color_out;
            got.in_clip = rsp_ch.inside_res;
            got.last    = rsp_ch.last;
            got.done    = rsp_ch.done_res;
            walk.check_write(got);
            writes_seen++;
            if (hold_writes && !held) begin
               gap  = LONG_HOLD;
               held = 1'b1;
            end else begin
               gap = sink_gap();
            end
         end else if (gap > 0) begin
            gap--;
         end
         rsp_ch.ready <= (gap == 0);
      end
   end

   initial begin : stimulus
      int unsigned clip_plan[6];
      walk = new();
      words_sent  = 0;
      hold_writes = 1'b0;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.opcode   <= crz_pkg::OP_START;
      req_ch.center_x <= '0;
      req_ch.center_y <= '0;
      req_ch.radius   <= '0;
      req_ch.color    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset clip limit
      send_step();
      send_word(crz_pkg::OP_START, 12'sd0, 12'sd0, 10'd0, 8'd0);
      send_step();
      send_step();
      send_word(crz_pkg::OP_START, 12'sd2047, -12'sd2048, 10'd1023, 8'hFF);
      send_step();
      send_step();
      // restart on top of a live circle
      send_word(crz_pkg::OP_START, -12'sd2048, 12'sd2047, 10'd1023, 8'h5A);
      send_step();
      send_word(crz_pkg::OP_START, 12'h555, 12'hAAA, 10'h2AA, 8'hAA);
      send_word(crz_pkg::OP_START, 12'hAAA, 12'h555, 10'h155, 8'h55);
      send_word(crz_pkg::OP_START, 12'sd400, 12'sd400, 10'd7, 8'h0F);
      while (walk.running) send_step();
      send_step();

      clip_plan = '{2047, 1, 0, 0, 0, 800};
      clip_plan[3] = $urandom_range(1, 2046);
      clip_plan[4] = $urandom_range(1, 2046);
      for (int p = 0; p < 6; p++) begin
         set_clip_limit(clip_plan[p]);
         if (p == 1) hold_writes = 1'b1;
         random_phase(12);
      end

      req_ch.valid <= 1'b0;
      wait_all_written();
      repeat (16) @(posedge clock);
      walk.check_drained();
      if (walk.failures == 0) begin
         $display("circle_rasterizer_unit_tb OK");
      end else begin
         $display("circle_rasterizer_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> circle_rasterizer_unit.f
sv/crz_pkg.sv
sv/crz_req_if.sv
sv/crz_rsp_if.sv
sv/crz_emitter.sv
sv/circle_rasterizer_unit.sv
sv/crz_checker.sv
sim/circle_rasterizer_unit_tb.sv
